@@ src/phf_pkg.sv @@
// shared types and constants for the ph sensor filter chain
package phf_pkg;

    localparam int unsigned VREF_W  = 23;
    localparam int unsigned FS_W    = 12;
    localparam int unsigned V7_W    = 23;
    localparam int unsigned SLOPE_W = 21;
    localparam int unsigned VOLT_W  = 23;
    localparam int unsigned HUND_W  = 11;
    localparam int unsigned PH_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [PH_W-1:0] PH_SEVEN = 16'd28672;
    localparam logic [PH_W-1:0] PH_MAX   = 16'd57344;
    localparam logic [VOLT_W-1:0] VOLT_MAX = 23'h7FFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF  = 2'd0,
        REG_FS    = 2'd1,
        REG_V7    = 2'd2,
        REG_SLOPE = 2'd3
    } reg_idx_t;

    // one group average handed from front to back
    typedef struct packed {
        logic [15:0] avg;
    } job_t;

    // shared serial divider request
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [33:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;

endpackage

@@ src/phf_ram.sv @@
// generic ram with separate write and read ports and registered read
module phf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/phf_div.sv @@
// restoring serial divider, one quotient bit per cycle
module phf_div
    import phf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [33:0] den_reg, den_next;
    logic [34:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[33:0], quo_reg[47]};
        if (req.start) begin
            quo_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

@@ src/phf_front.sv @@
// front end: accumulates samples and queues group averages
module phf_front
    import phf_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = 10,
    parameter int unsigned ADC_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    output logic                job_valid,
    input  logic                job_ready,
    output job_t                job
);
    localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_READING - 1);
    // reciprocal of the group size, exact for any 20-bit sum
    localparam logic [25:0] RECIP = 26'(((64'd1 << 25) + 64'(SAMPLES_PER_READING) - 64'd1)
                                        / 64'(SAMPLES_PER_READING));

    logic [19:0]      sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    job_t             q_reg [2];
    logic [1:0]       fill_reg, fill_next;
    logic [15:0]      sample;
    logic [19:0]      total;
    logic             push, pop;
    logic             to_head;
    logic [45:0]      quot_prod;
    logic [15:0]      grp_avg;

    assign sample    = s_tdata & 16'((32'd1 << ADC_BITS) - 1);
    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready && (cnt_reg == LAST);
    assign job_valid = (fill_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[0];
    assign total     = sum_reg + 20'(sample);
    assign quot_prod = 46'(total) * 46'(RECIP);
    assign grp_avg   = quot_prod[40:25];
    assign to_head   = (fill_reg == 2'd0) || (fill_reg == 2'd1 && pop);

    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
        if (s_tvalid && s_tready) begin
            if (cnt_reg == LAST) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = total;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            fill_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
        end
        if (push && to_head) begin
            q_reg[0].avg <= grp_avg;
        end else if (pop) begin
            q_reg[0] <= q_reg[1];
        end
        if (push && !to_head) begin
            q_reg[1].avg <= grp_avg;
        end
    end
endmodule

@@ src/phf_back.sv @@
// back end: voltage, ph, median and moving average
module phf_back
    import phf_pkg::*;
#(
    parameter int unsigned MEDIAN_DEPTH = 5,
    parameter int unsigned AVERAGE_DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [VREF_W-1:0]   vref_uv,
    input  logic [FS_W-1:0]     adc_full_scale,
    input  logic [V7_W-1:0]     volt_at_ph7_uv,
    input  logic [SLOPE_W-1:0]  slope_uv_per_ph,
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata
);
    localparam int unsigned MW = $clog2(MEDIAN_DEPTH > 1 ? MEDIAN_DEPTH : 2);
    localparam int unsigned AW = $clog2(AVERAGE_DEPTH > 1 ? AVERAGE_DEPTH : 2);
    localparam int unsigned NW = $clog2(AVERAGE_DEPTH + 1);
    localparam int unsigned MID = MEDIAN_DEPTH / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_VMUL, S_VDIV, S_PDIV, S_PH, S_MED, S_MEDW,
        S_AREAD, S_AACC, S_HDIV, S_OUT
    } state_t;

    state_t           state_reg;
    logic [39:0]      prod_reg;
    logic [VOLT_W-1:0] volt_reg;
    logic             neg_reg;
    logic [PH_W-1:0]  med_win_reg [MEDIAN_DEPTH];
    logic [MW-1:0]    mpos_reg;
    logic [MW:0]      mi_reg;
    logic [PH_W-1:0]  med_reg;
    logic [AW-1:0]    apos_reg;
    logic             afull_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    ai_reg;
    logic [PH_W+NW-1:0] asum_reg;
    logic [HUND_W-1:0] hund_reg;
    logic             rd_pend_reg;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [PH_W-1:0]  rdata;
    logic             we;
    logic [PH_W-1:0]  cand;
    logic [VOLT_W:0]  diffp;
    logic [VOLT_W-1:0] absd;
    logic [19:0]      qsat;
    logic [18:0]      p_calc;

    phf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign we = (state_reg == S_MEDW);
    phf_ram #(.WIDTH(PH_W), .DEPTH(AVERAGE_DEPTH)) u_avg_ram (
        .aclk(aclk), .we(we), .waddr(apos_reg), .wdata(med_reg),
        .raddr(ai_reg[AW-1:0]), .rdata(rdata)
    );

    assign diffp = {1'b0, volt_reg} - {1'b0, volt_at_ph7_uv};
    assign absd  = diffp[VOLT_W] ? VOLT_W'(-diffp) : diffp[VOLT_W-1:0];
    assign qsat  = (drsp.quo > 48'd65535) ? 20'd65535 : 20'(drsp.quo);
    assign cand  = med_win_reg[mi_reg[MW-1:0]];

    always_comb begin
        dreq = '0;
        if (state_reg == S_VMUL) begin
            dreq.start = 1'b1;
            dreq.num   = 48'(prod_reg);
            dreq.den   = 34'((adc_full_scale == '0) ? FS_W'(1) : adc_full_scale);
        end else if (state_reg == S_PDIV && !rd_pend_reg) begin
            dreq.start = 1'b1;
            dreq.num   = {13'd0, absd, 12'd0};
            dreq.den   = 34'((slope_uv_per_ph == '0) ? SLOPE_W'(1) : slope_uv_per_ph);
        end else if (state_reg == S_HDIV && !rd_pend_reg) begin
            dreq.start = 1'b1;
            dreq.num   = 48'(asum_reg) * 48'd100 + 48'({n_reg, 11'd0});
            dreq.den   = 34'({n_reg, 12'd0});
        end
        if (neg_reg) begin
            p_calc = 19'(PH_SEVEN) + 19'(qsat);
        end else begin
            p_calc = (20'(PH_SEVEN) >= qsat) ? 19'(20'(PH_SEVEN) - qsat) : 19'd0;
        end
    end

    assign job_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {6'd0, volt_reg, hund_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mpos_reg    <= '0;
            apos_reg    <= '0;
            afull_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < MEDIAN_DEPTH; i++) begin
                med_win_reg[i] <= PH_SEVEN;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        state_reg <= S_VMUL;
                        prod_reg  <= 40'(job.avg) * 40'(vref_uv);
                    end
                end
                S_VMUL: begin
                    rd_pend_reg <= 1'b1;
                    state_reg   <= S_VDIV;
                end
                S_VDIV: begin
                    if (drsp.done) begin
                        volt_reg    <= (drsp.quo > 48'(VOLT_MAX)) ? VOLT_MAX
                                                                : VOLT_W'(drsp.quo);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    neg_reg     <= diffp[VOLT_W];
                    rd_pend_reg <= 1'b1;
                    state_reg   <= S_PH;
                end
                S_PH: begin
                    if (drsp.done) begin
                        rd_pend_reg <= 1'b0;
                        mi_reg      <= '0;
                        state_reg   <= S_MED;
                        med_win_reg[mpos_reg] <= (p_calc > 19'(PH_MAX)) ? PH_MAX
                                                                        : PH_W'(p_calc);
                        mpos_reg <= (mpos_reg == MW'(MEDIAN_DEPTH - 1)) ? '0
                                                                       : mpos_reg + MW'(1);
                    end
                end
                S_MED: begin
                    // rank search: pick candidate with count below <= MID < below+equal
                    begin
                        logic [MW:0] b, e;
                        b = '0;
                        e = '0;
                        for (int k = 0; k < MEDIAN_DEPTH; k++) begin
                            b = b + (MW+1)'(med_win_reg[k] < cand);
                            e = e + (MW+1)'(med_win_reg[k] == cand);
                        end
                        if (b <= (MW+1)'(MID) && (MW+1)'(MID) < b + e) begin
                            med_reg   <= cand;
                            state_reg <= S_MEDW;
                        end else begin
                            mi_reg <= mi_reg + (MW+1)'(1);
                        end
                    end
                end
                S_MEDW: begin
                    apos_reg <= (apos_reg == AW'(AVERAGE_DEPTH - 1)) ? '0
                                                                     : apos_reg + AW'(1);
                    if (apos_reg == AW'(AVERAGE_DEPTH - 1)) begin
                        afull_reg <= 1'b1;
                        n_reg     <= NW'(AVERAGE_DEPTH);
                    end else begin
                        n_reg <= afull_reg ? NW'(AVERAGE_DEPTH) : NW'(apos_reg) + NW'(1);
                    end
                    ai_reg    <= '0;
                    asum_reg  <= '0;
                    state_reg <= S_AREAD;
                end
                S_AREAD: begin
                    state_reg <= S_AACC;
                end
                S_AACC: begin
                    asum_reg <= asum_reg + (PH_W+NW)'(rdata);
                    if (ai_reg + NW'(1) == n_reg) begin
                        state_reg <= S_HDIV;
                    end else begin
                        ai_reg    <= ai_reg + NW'(1);
                        state_reg <= S_AREAD;
                    end
                end
                S_HDIV: begin
                    if (!rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                    end else if (drsp.done) begin
                        hund_reg    <= HUND_W'(drsp.quo);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/ph_sensor_filter_chain_top.sv @@
// top level of the ph sensor filter chain
// Each input transaction carries one converter sample; every SAMPLES_PER_READING-th
// sample closes a group and one result transaction follows with the filtered pH in
// hundredths and the group's voltage in microvolts. Samples are taken every cycle
// while the two-entry group queue has room; each group then goes through the back end
// up to the result, by way of three passes through the shared serial divider (voltage,
// pH, rounding of the average) plus the median rank search and the average window
// read, one read and one accumulate state per entry. Configuration writes are taken
// any time but must only be made while the block is idle.
module ph_sensor_filter_chain_top
    import phf_pkg::*;
#(
    parameter int unsigned MEDIAN_DEPTH = 5,
    parameter int unsigned AVERAGE_DEPTH = 8,
    parameter int unsigned SAMPLES_PER_READING = 10,
    parameter int unsigned ADC_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // adc_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // ph_hundredths, voltage_uv
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [VREF_W-1:0]  vref_reg;
    logic [FS_W-1:0]    fs_reg;
    logic [V7_W-1:0]    v7_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic               job_valid, job_ready;
    job_t               job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg  <= VREF_W'(3300000);
            fs_reg    <= FS_W'(4095);
            v7_reg    <= V7_W'(2500000);
            slope_reg <= SLOPE_W'(180000);
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_VREF:  vref_reg  <= cfg_data[VREF_W-1:0];
                REG_FS:    fs_reg    <= cfg_data[FS_W-1:0];
                REG_V7:    v7_reg    <= cfg_data[V7_W-1:0];
                REG_SLOPE: slope_reg <= cfg_data[SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    phf_front #(.SAMPLES_PER_READING(SAMPLES_PER_READING), .ADC_BITS(ADC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    phf_back #(.MEDIAN_DEPTH(MEDIAN_DEPTH), .AVERAGE_DEPTH(AVERAGE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .vref_uv(vref_reg), .adc_full_scale(fs_reg),
        .volt_at_ph7_uv(v7_reg), .slope_uv_per_ph(slope_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_ph_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:0] <= 11'd1400) else $error("ph out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_queue_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> !m_tvalid) else $error("result without work");
`endif
endmodule

@@ tb/tb.sv @@
// self-checking testbench for the ph sensor filter chain
`timescale 1ns / 1ps

module tb;
    import phf_pkg::*;

    localparam int MED_N = 5;
    localparam int AVG_N = 8;
    localparam int GROUP_N = 10;

    typedef struct {
        logic [HUND_W-1:0] ph_hundredths;
        logic [VOLT_W-1:0] voltage_uv;
    } reading_t;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [23:0] data;
        logic [11:0] sample;
    } item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ph_sensor_filter_chain_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    longint unsigned p_vref, p_fs, p_v7, p_slope;
    longint unsigned grp_sum;
    int              grp_cnt;
    longint unsigned med_win [MED_N];
    int              med_pos;
    longint unsigned avg_win [AVG_N];
    int              avg_pos;
    bit              avg_full;

    reading_t expected_readings[$];
    item_t    pending[$];
    int       errors = 0;
    bit       idle_on = 1'b1;
    bit       recv_hold = 1'b0;
    bit       send_pause = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void predict_config(reg_idx_t idx, logic [23:0] d);
        case (idx)
            REG_VREF: p_vref = d[22:0];
            REG_FS: p_fs = d[11:0];
            REG_V7: p_v7 = d[22:0];
            REG_SLOPE: p_slope = d[20:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_sample(logic [11:0] smp);
        longint unsigned avg, fs, v, sum, n, den, tmp[MED_N], x;
        longint diff, q, p, sl;
        int j;
        reading_t r;
        grp_sum += smp;
        grp_cnt++;
        if (grp_cnt < GROUP_N) return;
        avg = grp_sum / GROUP_N;
        grp_sum = 0;
        grp_cnt = 0;
        fs = (p_fs != 0) ? p_fs : 1;
        v = (avg * p_vref) / fs;
        if (v > 64'd8388607) v = 64'd8388607;
        sl = (p_slope != 0) ? longint'(p_slope) : 1;
        diff = longint'(v) - longint'(p_v7);
        q = (diff < 0) ? -((-diff * 4096) / sl) : (diff * 4096) / sl;
        p = 28672 - q;
        if (p < 0) p = 0;
        if (p > 57344) p = 57344;
        med_win[med_pos] = p;
        med_pos = (med_pos + 1) % MED_N;
        tmp = med_win;
        for (int i = 1; i < MED_N; i++) begin
            x = tmp[i];
            j = i;
            while (j > 0 && tmp[j-1] > x) begin
                tmp[j] = tmp[j-1];
                j--;
            end
            tmp[j] = x;
        end
        avg_win[avg_pos] = tmp[MED_N/2];
        avg_pos = (avg_pos + 1) % AVG_N;
        if (avg_pos == 0) avg_full = 1'b1;
        n = avg_full ? AVG_N : avg_pos;
        sum = 0;
        for (int i = 0; i < n; i++) sum += avg_win[i];
        den = n * 4096;
        r.ph_hundredths = HUND_W'((sum * 100 + den / 2) / den);
        r.voltage_uv = VOLT_W'(v);
        expected_readings.push_back(r);
    endfunction

    // driver
    always @(posedge aclk) begin
        item_t it;
        if (aresetn) begin
            if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
            end else if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                cfg_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!send_pause && pending.size() > 0 &&
                         !(pending[0].is_cfg && expected_readings.size() > 0)) begin
                it = pending.pop_front();
                if (it.is_cfg) begin
                    s_tvalid <= 1'b0;
                    cfg_valid <= 1'b1;
                    cfg_index <= it.idx;
                    cfg_data <= it.data;
                    predict_config(it.idx, it.data);
                end else begin
                    cfg_valid <= 1'b0;
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, it.sample};
                    predict_sample(it.sample);
                end
                if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
                cfg_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        reading_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    w = expected_readings.pop_front();
                    if (m_tdata[10:0] != w.ph_hundredths)
                        report("ph_hundredths", m_tdata[10:0], w.ph_hundredths);
                    if (m_tdata[33:11] != w.voltage_uv)
                        report("voltage_uv", m_tdata[33:11], w.voltage_uv);
                end
            end
            if (recv_hold) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 7);
            end
        end
    end

    task automatic add_cfg(reg_idx_t idx, logic [23:0] d);
        item_t it;
        it.is_cfg = 1'b1;
        it.idx = idx;
        it.data = d;
        it.sample = '0;
        pending.push_back(it);
    endtask

    task automatic add_sample(logic [11:0] smp);
        item_t it;
        it.is_cfg = 1'b0;
        it.idx = REG_VREF;
        it.data = '0;
        it.sample = smp;
        pending.push_back(it);
    endtask

    task automatic add_group(int kind);
        logic [11:0] base;
        base = 12'($urandom_range(0, 4095));
        for (int i = 0; i < GROUP_N; i++) begin
            case (kind)
                0: add_sample(12'($urandom_range(0, 4095)));
                1: add_sample(base);
                default: add_sample(12'(32'(base) + $urandom_range(0, 40)));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || expected_readings.size() > 0 || s_tvalid || cfg_valid)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        logic [23:0] vr, fsv, v7, sl;
        p_vref = 3300000;
        p_fs = 4095;
        p_v7 = 2500000;
        p_slope = 180000;
        grp_sum = 0;
        grp_cnt = 0;
        for (int i = 0; i < MED_N; i++) med_win[i] = 28672;
        med_pos = 0;
        for (int i = 0; i < AVG_N; i++) avg_win[i] = 0;
        avg_pos = 0;
        avg_full = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes at reset settings
        for (int i = 0; i < GROUP_N; i++) add_sample(12'hFFF);
        for (int i = 0; i < GROUP_N; i++) add_sample(12'h000);
        for (int i = 0; i < 5; i++) add_sample(12'hAAA);
        for (int i = 0; i < 5; i++) add_sample(12'h555);
        wait_drained();

        // zero full scale, zero slope, voltage overflow
        add_cfg(REG_VREF, 24'd5000000);
        add_cfg(REG_FS, 24'd0);
        add_cfg(REG_V7, 24'd0);
        add_cfg(REG_SLOPE, 24'd0);
        add_group(1);
        add_cfg(REG_FS, 24'd1);
        add_cfg(REG_SLOPE, 24'd2000000);
        add_cfg(REG_V7, 24'd5000000);
        add_group(0);
        add_cfg(REG_VREF, 24'd1);
        add_cfg(REG_FS, 24'd4095);
        add_cfg(REG_V7, 24'h7FFFFF);
        add_cfg(REG_SLOPE, 24'h1FFFFF);
        add_group(0);
        wait_drained();

        // receiver holds off while the sender keeps offering
        recv_hold = 1'b1;
        for (int i = 0; i < 4; i++) add_group(2);
        repeat (2000) @(posedge aclk);
        recv_hold = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin vr = 24'd3300000; fsv = 24'd4095; v7 = 24'd2500000; sl = 24'd180000; end
                1: begin vr = 24'd5000000; fsv = 24'd4095; v7 = 24'd0; sl = 24'd59000; end
                2: begin vr = 24'd1; fsv = 24'd1; v7 = 24'd5000000; sl = 24'd1; end
                default: begin
                    vr = 24'($urandom_range(1, 5000000));
                    fsv = 24'($urandom_range(1, 4095));
                    v7 = 24'($urandom_range(0, 5000000));
                    sl = 24'($urandom_range(1, 2000000));
                end
            endcase
            add_cfg(REG_VREF, vr);
            add_cfg(REG_FS, fsv);
            add_cfg(REG_V7, v7);
            add_cfg(REG_SLOPE, sl);
            if (ph == 5) idle_on = 1'b0;
            for (int g = 0; g < 16; g++) begin
                add_group($urandom_range(0, 2));
                if (g == 8 && ph == 2) begin
                    while (pending.size() > 0) @(posedge aclk);
                    send_pause = 1'b1;
                    while (expected_readings.size() > 0) @(posedge aclk);
                    send_pause = 1'b0;
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
